// ----- sv/i2c_master_bit_engine_top_defines.svh -----
// ----------------------------------------------------------------------------
// i2c master bit engine assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
`define I2CM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2cm assertion failed");
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int HP_W = 10;
	localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 10'd32;
	localparam logic [HP_W-1:0] HALF_PERIOD_MIN = 10'd1;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [3:0] LAST_BIT_INDEX = 4'd9;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ST_W1,
		PH_ST_W2,
		PH_SP_W1,
		PH_SP_W2,
		PH_SP_W3,
		PH_BIT_A,
		PH_BIT_B
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] operation;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       nack_seen;
	} out_item_t;

	typedef struct packed {
		phase_t          phase;
		logic [HP_W-1:0] wait_count;
		logic [3:0]      bit_index;
		logic [7:0]      shift_data;
		logic [1:0]      active_op;
		logic            ack_choice;
		logic            scl_drive;
		logic            sda_drive;
		logic            last_nack;
		logic [7:0]      received_byte;
	} eng_state_t;

endpackage

// ----- sv/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cm_engine
// bus state registers and the one-tick update of the i2c master sequencer
// ----------------------------------------------------------------------------
module i2cm_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [i2cm_pkg::HP_W-1:0] half_period,
	input  i2cm_pkg::in_item_t        item,
	output i2cm_pkg::out_item_t       res
);
	import i2cm_pkg::*;

	eng_state_t state_q;
	eng_state_t nxt;
	logic [HP_W-1:0] per;
	logic done;
	logic start_bit;

	assign per = (half_period == '0) ? HALF_PERIOD_MIN : half_period;

	always_comb begin
		nxt = state_q;
		done = 1'b0;
		start_bit = 1'b0;
		if (state_q.phase == PH_IDLE) begin
			if (item.cmd_valid) begin
				nxt.active_op = item.operation;
				nxt.ack_choice = item.send_ack;
				case (item.operation)
					OP_START: begin
						nxt.sda_drive = 1'b0;
						nxt.scl_drive = 1'b0;
						nxt.wait_count = per;
						nxt.phase = PH_ST_W1;
					end
					OP_STOP: begin
						nxt.sda_drive = 1'b1;
						nxt.wait_count = per;
						nxt.phase = PH_SP_W1;
					end
					OP_WRITE: begin
						nxt.shift_data = item.tx_byte;
						nxt.bit_index = '0;
						start_bit = 1'b1;
					end
					default: begin
						nxt.shift_data = '0;
						nxt.bit_index = '0;
						start_bit = 1'b1;
					end
				endcase
			end
		end else if (state_q.wait_count > HALF_PERIOD_MIN) begin
			nxt.wait_count = state_q.wait_count - HALF_PERIOD_MIN;
		end else begin
			nxt.wait_count = per;
			case (state_q.phase)
				PH_ST_W1: begin
					nxt.sda_drive = 1'b1;
					nxt.phase = PH_ST_W2;
				end
				PH_ST_W2: begin
					nxt.scl_drive = 1'b1;
					done = 1'b1;
				end
				PH_SP_W1: begin
					nxt.scl_drive = 1'b0;
					nxt.phase = PH_SP_W2;
				end
				PH_SP_W2: begin
					nxt.sda_drive = 1'b0;
					nxt.phase = PH_SP_W3;
				end
				PH_SP_W3: begin
					done = 1'b1;
				end
				PH_BIT_A: begin
					nxt.scl_drive = 1'b0;
					nxt.phase = PH_BIT_B;
				end
				default: begin
					if (state_q.active_op == OP_WRITE) begin
						if (state_q.bit_index < BITS_PER_BYTE) begin
							nxt.shift_data = {state_q.shift_data[6:0], 1'b0};
						end else begin
							nxt.last_nack = item.sda_in;
						end
					end else if (state_q.bit_index < BITS_PER_BYTE) begin
						nxt.shift_data = {state_q.shift_data[6:0], item.sda_in};
					end
					nxt.scl_drive = 1'b1;
					nxt.bit_index = state_q.bit_index + 4'd1;
					if (nxt.bit_index >= LAST_BIT_INDEX) begin
						if (state_q.active_op == OP_READ) begin
							nxt.received_byte = nxt.shift_data;
						end
						done = 1'b1;
					end else begin
						start_bit = 1'b1;
					end
				end
			endcase
		end
		if (start_bit) begin
			if (nxt.bit_index < BITS_PER_BYTE) begin
				nxt.sda_drive = (nxt.active_op == OP_WRITE) ? ~nxt.shift_data[7] : 1'b0;
			end else begin
				nxt.sda_drive = (nxt.active_op == OP_WRITE) ? 1'b0 : nxt.ack_choice;
			end
			nxt.wait_count = per;
			nxt.phase = PH_BIT_A;
		end
		if (done) begin
			nxt.phase = PH_IDLE;
			nxt.wait_count = '0;
		end
	end

	always_comb begin
		res.scl_low = nxt.scl_drive;
		res.sda_low = nxt.sda_drive;
		res.busy_res = (nxt.phase != PH_IDLE);
		res.done_res = done;
		res.rx_byte = nxt.received_byte;
		res.nack_seen = nxt.last_nack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (en) begin
			state_q <= nxt;
		end
	end

endmodule

// ----- sv/i2c_master_bit_engine_top.sv -----
// path: a tick accepted into the input register passes through the engine update
// and is written into the result register when the result register can take it
// throughput: one tick per clock cycle while the result register is not stalled;
// the engine state is updated in one pass between the input and result registers
// reset: arst_n clears the bus state (both lines released, idle) and loads
// the default half period of 32 ticks
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// open-drain i2c master bit engine with input and result registers
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_top_defines.svh"

module i2c_master_bit_engine_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  i2cm_pkg::in_item_t        in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output i2cm_pkg::out_item_t       out_item,
	input  logic                      cfg_wr_en,
	input  logic [i2cm_pkg::HP_W-1:0] cfg_wr_data
);
	import i2cm_pkg::*;

	logic [HP_W-1:0] half_period_q;
	in_item_t in_item_s1;
	logic in_valid_s1;
	out_item_t out_item_s2;
	logic out_valid_s2;
	out_item_t res;
	logic advance;

	assign advance = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;
	assign out_valid = out_valid_s2;
	assign out_item = out_item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			half_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_item_s1 <= in_item;
		end
		if (advance) begin
			out_item_s2 <= res;
		end
	end

	i2cm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.half_period (half_period_q),
		.item        (in_item_s1),
		.res         (res)
	);

	`I2CM_ASSERT_SAME(a_done_not_busy, clk, arst_n,
		out_valid_s2 && out_item_s2.done_res, !out_item_s2.busy_res)
	`I2CM_ASSERT_SAME(a_no_advance_on_stall, clk, arst_n,
		out_valid_s2 && !out_ready, !advance)
	`I2CM_ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance, out_valid_s2)

endmodule
